[hw/rtl/gpkev_pkg.sv]
// Shared types, constants and helpers for the gamepad report to key event block.
package gpkev_pkg;

  localparam int ButtonCount = 16;
  localparam int IdxWidth    = $clog2(ButtonCount);
  localparam int MapRegs     = 4;
  localparam int AddrWidth   = 4;

  localparam logic [7:0] AxisMin    = 8'h00;
  localparam logic [7:0] AxisMax    = 8'hff;
  localparam logic [7:0] LeftBit    = 8'h80;
  localparam logic [7:0] RightBit   = 8'h40;
  localparam logic [7:0] UpBit      = 8'h20;
  localparam logic [7:0] DownBit    = 8'h10;
  localparam logic [7:0] ReleaseBit = 8'h80;

  localparam logic [31:0] KeyMap0Reset = 32'h2614_0000;
  localparam logic [31:0] KeyMap1Reset = 32'h002e_1e00;
  localparam logic [31:0] KeyMap2Reset = 32'h3e3c_3d3b;
  localparam logic [31:0] KeyMap3Reset = 32'h131f_0000;

  typedef enum logic [1:0] {
    REG_KEY_MAP_0 = 2'd0,
    REG_KEY_MAP_1 = 2'd1,
    REG_KEY_MAP_2 = 2'd2,
    REG_KEY_MAP_3 = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] button_high;
    logic [7:0] button_low;
    logic [7:0] x_axis;
    logic [7:0] y_axis;
    logic       transfer_error;
  } report_t;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       key_released;
    logic       last_event;
  } key_event_t;

  // One queued report: which buttons changed and the new button word.
  typedef struct packed {
    logic [ButtonCount-1:0] changed;
    logic [ButtonCount-1:0] word;
  } pending_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef logic [ButtonCount-1:0][7:0] key_table_t;

  // Merge the axis bytes into the low button byte and form the button word.
  function automatic logic [ButtonCount-1:0] merge_buttons(input report_t r);
    logic [7:0] lo;
    lo = r.button_low;
    if (r.x_axis == AxisMin) begin
      lo = lo | LeftBit;
    end else if (r.x_axis == AxisMax) begin
      lo = lo | RightBit;
    end
    if (r.y_axis == AxisMin) begin
      lo = lo | UpBit;
    end else if (r.y_axis == AxisMax) begin
      lo = lo | DownBit;
    end
    return {r.button_high, lo};
  endfunction

endpackage

[hw/rtl/gpkev_front.sv]
// Front end: takes reports, merges directions, diffs against the previous word.
module gpkev_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  gpkev_pkg::report_t           in_data,
  input  gpkev_pkg::queue_status_t     q_status,
  output logic                         q_push,
  output gpkev_pkg::pending_t          q_push_data,
  output logic                         halted
);
  import gpkev_pkg::*;

  logic [ButtonCount-1:0] previous_buttons;
  logic [ButtonCount-1:0] word;
  logic                   accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign word     = merge_buttons(in_data);

  assign q_push_data.word    = word;
  assign q_push_data.changed = word ^ previous_buttons;
  assign q_push = accept && !halted && !in_data.transfer_error &&
                  (q_push_data.changed != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_buttons <= '0;
      halted           <= 1'b0;
    end else if (accept && !halted) begin
      if (in_data.transfer_error) begin
        halted <= 1'b1;
      end else begin
        previous_buttons <= word;
      end
    end
  end

endmodule

[hw/rtl/gpkev_queue.sv]
// Two-entry queue of pending reports between the front and back ends.
module gpkev_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  gpkev_pkg::pending_t      push_data,
  input  logic                     pop,
  output gpkev_pkg::pending_t      pop_data,
  output gpkev_pkg::queue_status_t status
);
  import gpkev_pkg::*;

  pending_t    entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/gpkev_back.sv]
// Back end: walks the changed bits of one report and emits one key event a cycle while out_stall does not hold it.
module gpkev_back (
  input  logic                          clk,
  input  logic                          rst,
  input  gpkev_pkg::key_table_t         key_table,
  input  gpkev_pkg::queue_status_t      q_status,
  input  gpkev_pkg::pending_t           q_pop_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gpkev_pkg::key_event_t         out_data
);
  import gpkev_pkg::*;

  logic [ButtonCount-1:0] mask;
  logic [ButtonCount-1:0] word;
  logic [ButtonCount-1:0] rest;
  logic [IdxWidth-1:0]    idx;
  logic                   slot_free;
  logic                   emit;
  logic                   released;
  key_event_t             event_next;

  // Lowest set bit of the remaining mask.
  always_comb begin
    idx = '0;
    for (int i = ButtonCount - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = IdxWidth'(i);
      end
    end
  end

  assign rest      = mask & (mask - 1'b1);
  assign slot_free = !out_valid || !out_stall;
  assign emit      = (mask != '0) && slot_free;
  assign q_pop     = (mask == '0) && !q_status.empty;
  assign released  = !word[idx];

  // Bit i uses map entry 15 - i, which is the bitwise inverse of the index.
  assign event_next.key_byte     = key_table[~idx] | (released ? ReleaseBit : 8'h00);
  assign event_next.key_released = released;
  assign event_next.last_event   = (rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        mask <= q_pop_data.changed;
      end else if (emit) begin
        mask <= rest;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word <= q_pop_data.word;
    end
    if (emit) begin
      out_data <= event_next;
    end
  end

endmodule

[hw/rtl/gamepad_report_to_key_events.sv]
// Top level of the gamepad report to key event block with its register port.
//
//   channel   direction  handshake                     payload
//   in        input      in_valid / in_stall            report_t (4 bytes + error)
//   out       output     out_valid / out_stall          key_event_t
//   config    input      psel/penable/pwrite/pready     key_map_0..3 at 0x0..0xC
//
// The front end takes one report transfer per cycle while the two-entry queue
// has room; reports that change nothing, fail, or arrive while halted are
// consumed without entering the queue. The back end loads a queued report,
// then emits one key event per changed button, held back by any out_stall,
// and pops the next report only once the current one is done. Reset is
// synchronous and clears the previous button word, the halt flag, the queue
// and the output; the key map returns to its defaults.
// A report with transfer_error set halts the block until the next reset.
module gamepad_report_to_key_events (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  gpkev_pkg::report_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output gpkev_pkg::key_event_t              out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gpkev_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import gpkev_pkg::*;

  logic [31:0]   key_map [MapRegs];
  reg_idx_t      reg_sel;
  key_table_t    key_table;
  queue_status_t q_status;
  pending_t      q_push_data;
  pending_t      q_pop_data;
  logic          q_push;
  logic          q_pop;
  logic          halted;

  // Register file. pready is held high, so every access completes without wait states.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[AddrWidth-1:2]);
  assign prdata  = key_map[reg_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_map[REG_KEY_MAP_0] <= KeyMap0Reset;
      key_map[REG_KEY_MAP_1] <= KeyMap1Reset;
      key_map[REG_KEY_MAP_2] <= KeyMap2Reset;
      key_map[REG_KEY_MAP_3] <= KeyMap3Reset;
    end else if (psel && penable && pwrite && pready) begin
      key_map[reg_sel] <= pwdata;
    end
  end

  // Entry 4r+n of the key table sits in byte n of register r.
  assign key_table = {key_map[REG_KEY_MAP_3], key_map[REG_KEY_MAP_2],
                      key_map[REG_KEY_MAP_1], key_map[REG_KEY_MAP_0]};

  gpkev_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_push_data (q_push_data),
    .halted      (halted)
  );

  gpkev_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  gpkev_back u_back (
    .clk        (clk),
    .rst        (rst),
    .key_table  (key_table),
    .q_status   (q_status),
    .q_pop_data (q_pop_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Once halted, no report may reach the queue.
  a_halt_blocks_push: assert property (@(posedge clk) disable iff (rst)
    halted |-> !q_push)
    else $error("report queued while halted");

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("queue overflow");

  // Only reports with at least one changed button are handed to the back end.
  a_pop_has_work: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_pop_data.changed != '0))
    else $error("empty report popped");

  // A release always carries the release bit in its key byte.
  a_release_bit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.key_released) |-> out_data.key_byte[7])
    else $error("release without release bit");

endmodule

[tb/gamepad_report_to_key_events_test.sv]
// Self-checking testbench for the gamepad report to key event block.
module gamepad_report_to_key_events_test;
  import gpkev_pkg::*;

  // Margin of quiet cycles after the last predicted key event has come out, so
  // the back end is back at rest before a register is written.
  localparam int SETTLE_CYCLES = 24;
  // A transfer must happen on some channel at least this often, or the run is hung.
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 78;
  localparam int PREDICTED = -1;

  localparam key_event_t NO_KEY = '0;

  // A stimulus row either sends one report or writes one key map register.
  typedef enum logic {
    ROW_REPORT,
    ROW_CONFIG
  } row_kind_t;

  // Key events typed into the table for a report; when typed is low the
  // events come from the predictor instead.
  typedef struct packed {
    logic                  typed;
    logic [1:0]            count;
    key_event_t [1:0]      ev;
  } expect_t;

  typedef struct packed {
    row_kind_t   kind;
    report_t     rpt;
    reg_idx_t    idx;
    logic [31:0] value;
    expect_t     want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  report_t              in_data = '0;
  expect_t              in_want = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  key_event_t           out_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Predictor state: the key map as last written, the previous button word
  // and whether a failed transfer has halted the block.
  logic [31:0] map_words [0:3];
  logic [15:0] button_state;
  logic        halted_seen;
  key_event_t  expected_keys [$];

  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;
  logic idle_on = 1'b1;

  gamepad_report_to_key_events dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle and stall lengths: usually short or none, now and then a long one.
  function automatic int pause_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return $urandom_range(0, 2);
    end
    if (pick < 95) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(10, 30);
  endfunction

  // Stick positions favor the two end stops, which are the only values that
  // press a direction; everything else reads as centered.
  function automatic logic [7:0] axis_value();
    case ($urandom_range(0, 3))
      0: begin
        return AxisMin;
      end
      1: begin
        return AxisMax;
      end
      default: begin
        return 8'($urandom_range(1, 254));
      end
    endcase
  endfunction

  // Next report of a player at the pad: usually a few buttons or a stick move
  // away from the last one, sometimes identical, sometimes pure noise.
  function automatic report_t next_report(report_t prev);
    report_t r;
    int      pick;
    int      b;
    r = prev;
    r.transfer_error = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      repeat ($urandom_range(1, 3)) begin
        b = $urandom_range(0, 15);
        if (b < 8) begin
          r.button_low[b] = ~r.button_low[b];
        end else begin
          r.button_high[b - 8] = ~r.button_high[b - 8];
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        r.x_axis = axis_value();
      end
      if ($urandom_range(0, 2) == 0) begin
        r.y_axis = axis_value();
      end
    end else if (pick < 70) begin
      // Same report again, which must produce no key events.
    end else if (pick < 85) begin
      r.x_axis = axis_value();
      r.y_axis = axis_value();
    end else begin
      r.button_high = 8'($urandom);
      r.button_low = 8'($urandom);
      r.x_axis = 8'($urandom);
      r.y_axis = 8'($urandom);
    end
    return r;
  endfunction

  // Works out the key events that one accepted report causes and advances the
  // button word. With record low only the state moves, for rows whose events
  // are typed into the table.
  function automatic void predict_key_events(report_t r, logic record);
    logic [7:0]  low;
    logic [15:0] word;
    logic [15:0] flips;
    logic [3:0]  entry;
    int          remaining;
    key_event_t  ev;
    if (halted_seen) begin
      return;
    end
    if (r.transfer_error) begin
      halted_seen = 1'b1;
      return;
    end
    low = r.button_low;
    if (r.x_axis == AxisMin) begin
      low = low | LeftBit;
    end else if (r.x_axis == AxisMax) begin
      low = low | RightBit;
    end
    if (r.y_axis == AxisMin) begin
      low = low | UpBit;
    end else if (r.y_axis == AxisMax) begin
      low = low | DownBit;
    end
    word = {r.button_high, low};
    flips = word ^ button_state;
    button_state = word;
    remaining = $countones(flips);
    for (int b = 0; b < ButtonCount; b++) begin
      if (flips[b]) begin
        // Button b reads its code from the mirrored map entry.
        entry = 4'(ButtonCount - 1 - b);
        ev.key_byte = map_words[entry[3:2]][entry[1:0] * 8 +: 8];
        ev.key_released = ~word[b];
        if (!word[b]) begin
          ev.key_byte = ev.key_byte | ReleaseBit;
        end
        remaining--;
        ev.last_event = (remaining == 0);
        if (record) begin
          expected_keys.push_back(ev);
        end
      end
    end
  endfunction

  function automatic key_event_t key_ev(logic [7:0] code, logic released, logic last);
    return '{key_byte: code, key_released: released, last_event: last};
  endfunction

  // A count of PREDICTED leaves the events to the predictor.
  function automatic row_t report_row(logic [7:0] hi, logic [7:0] lo, logic [7:0] x,
                                      logic [7:0] y, logic err, int count,
                                      key_event_t first, key_event_t second);
    row_t row;
    row = '0;
    row.kind = ROW_REPORT;
    row.rpt = '{hi, lo, x, y, err};
    row.want.typed = (count >= 0);
    row.want.count = 2'(count);
    row.want.ev[0] = first;
    row.want.ev[1] = second;
    return row;
  endfunction

  function automatic row_t config_row(reg_idx_t idx, logic [31:0] value);
    row_t row;
    row = '0;
    row.kind = ROW_CONFIG;
    row.idx = idx;
    row.value = value;
    return row;
  endfunction

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Offers one report and holds it until the block takes the transfer. The
  // valid line only drops for a gap, never in the step where it rises again.
  task automatic send_report(report_t r, expect_t w);
    int gap;
    gap = idle_on ? pause_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    in_want <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending and waits until every predicted key event has come out,
  // then lets the back end run dry before anything else happens. The first
  // edge lets the monitor record the report taken at the calling edge.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: a setup phase, then an access phase that completes at
  // the first edge with pready high, then the port returns to idle.
  task automatic write_map(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    map_words[idx] = value;
    @(posedge clk);
  endtask

  task automatic run_row(row_t row);
    if (row.kind == ROW_CONFIG) begin
      settle();
      write_map(row.idx, row.value);
    end else begin
      send_report(row.rpt, row.want);
    end
  endtask

  // Both channels are observed at the clock edge, so the monitor sees the
  // values that the block itself sampled. A report taken in this cycle is
  // predicted before any key event of the same cycle is compared.
  always @(posedge clk) begin : monitor
    key_event_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (in_want.typed) begin
          for (int n = 0; n < int'(in_want.count); n++) begin
            expected_keys.push_back(in_want.ev[n]);
          end
          predict_key_events(in_data, 1'b0);
        end else begin
          predict_key_events(in_data, 1'b1);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: unexpected key event, expected none, got %h/%b/%b", $time,
                   out_data.key_byte, out_data.key_released, out_data.last_event);
          mismatches++;
        end else begin
          want = expected_keys.pop_front();
          check_field("key_byte", want.key_byte, out_data.key_byte);
          check_field("key_released", 8'(want.key_released), 8'(out_data.key_released));
          check_field("last_event", 8'(want.last_event), 8'(out_data.last_event));
        end
      end
    end
  end

  // The receiver stalls in bursts of random length while idling is enabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left <= pause_length();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Any transfer on either channel or the register port counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d key events outstanding", $time,
               QUIET_LIMIT, expected_keys.size());
      $display("gamepad_report_to_key_events verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    report_t rpt;
    row_t    opening_rows [0:26];
    row_t    halt_rows [0:5];

    map_words[0] = KeyMap0Reset;
    map_words[1] = KeyMap1Reset;
    map_words[2] = KeyMap2Reset;
    map_words[3] = KeyMap3Reset;
    button_state = '0;
    halted_seen = 1'b0;

    // Opening rows run on the default key map first. The typed events follow
    // from that map: left, right, up and down sit in entries 8 to 11, bit 0
    // reads entry 15 and bit 15 reads entry 0.
    opening_rows = '{
      // Stick to the left end stop presses left.
      report_row(8'h00, 8'h00, 8'h00, 8'h80, 1'b0, 1, key_ev(8'h3b, 0, 1), NO_KEY),
      // Left to right: the press on the lower bit comes out first.
      report_row(8'h00, 8'h00, 8'hff, 8'h80, 1'b0, 2,
                 key_ev(8'h3d, 0, 0), key_ev(8'hbb, 1, 1)),
      report_row(8'h00, 8'h00, 8'h80, 8'h00, 1'b0, 2,
                 key_ev(8'h3c, 0, 0), key_ev(8'hbd, 1, 1)),
      report_row(8'h00, 8'h00, 8'h80, 8'hff, 1'b0, 2,
                 key_ev(8'h3e, 0, 0), key_ev(8'hbc, 1, 1)),
      // Mid values and values one step inside the end stops count as centered.
      report_row(8'h00, 8'h00, 8'h7f, 8'h7f, 1'b0, 1, key_ev(8'hbe, 1, 1), NO_KEY),
      report_row(8'h00, 8'h00, 8'h01, 8'hfe, 1'b0, 0, NO_KEY, NO_KEY),
      // Every button pressed at once, then the same word again with the
      // opposite stick stops, which adds no new bit.
      report_row(8'hff, 8'hff, 8'h00, 8'h00, 1'b0, PREDICTED, NO_KEY, NO_KEY),
      report_row(8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 0, NO_KEY, NO_KEY),
      report_row(8'h00, 8'h00, 8'h01, 8'hfe, 1'b0, PREDICTED, NO_KEY, NO_KEY),
      report_row(8'h80, 8'h00, 8'h80, 8'h80, 1'b0, 1, key_ev(8'h00, 0, 1), NO_KEY),
      report_row(8'h01, 8'h00, 8'h80, 8'h80, 1'b0, 2,
                 key_ev(8'h00, 0, 0), key_ev(8'h80, 1, 1)),
      report_row(8'h00, 8'h01, 8'h80, 8'h80, 1'b0, 2,
                 key_ev(8'h13, 0, 0), key_ev(8'h80, 1, 1)),
      report_row(8'h55, 8'haa, 8'h80, 8'h80, 1'b0, PREDICTED, NO_KEY, NO_KEY),
      report_row(8'haa, 8'h55, 8'h00, 8'hff, 1'b0, PREDICTED, NO_KEY, NO_KEY),
      // All entries with the top bit set: a press still reports no release.
      config_row(REG_KEY_MAP_0, 32'hffff_ffff),
      config_row(REG_KEY_MAP_1, 32'hffff_ffff),
      config_row(REG_KEY_MAP_2, 32'hffff_ffff),
      config_row(REG_KEY_MAP_3, 32'hffff_ffff),
      report_row(8'h80, 8'h00, 8'h80, 8'h80, 1'b0, PREDICTED, NO_KEY, NO_KEY),
      report_row(8'h00, 8'h00, 8'h80, 8'h80, 1'b0, 1, key_ev(8'hff, 1, 1), NO_KEY),
      report_row(8'h80, 8'h00, 8'h80, 8'h80, 1'b0, 1, key_ev(8'hff, 0, 1), NO_KEY),
      // All-zero map: releases differ from presses only in the top bit.
      config_row(REG_KEY_MAP_0, 32'h0000_0000),
      config_row(REG_KEY_MAP_1, 32'h0000_0000),
      config_row(REG_KEY_MAP_2, 32'h0000_0000),
      config_row(REG_KEY_MAP_3, 32'h0000_0000),
      report_row(8'hff, 8'hff, 8'h00, 8'h00, 1'b0, PREDICTED, NO_KEY, NO_KEY),
      report_row(8'h00, 8'h00, 8'h01, 8'hfe, 1'b0, PREDICTED, NO_KEY, NO_KEY)
    };

    // A failed transfer halts the block for good, so these rows close the run.
    // Nothing may come out of them, and a register write is still taken.
    halt_rows = '{
      report_row(8'haa, 8'h55, 8'h80, 8'h80, 1'b1, 0, NO_KEY, NO_KEY),
      report_row(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, NO_KEY, NO_KEY),
      config_row(REG_KEY_MAP_2, 32'h3e3c_3d3b),
      report_row(8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 0, NO_KEY, NO_KEY),
      report_row(8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 0, NO_KEY, NO_KEY),
      report_row(8'h00, 8'h00, 8'h80, 8'h80, 1'b0, PREDICTED, NO_KEY, NO_KEY)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[r]) begin
      run_row(opening_rows[r]);
    end

    // Random play in several phases, each on a fresh random key map. The first
    // phase runs with no idling at all so that transfers go back to back.
    rpt = '{8'h00, 8'h00, 8'h80, 8'h80, 1'b0};
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      idle_on <= (phase != 0);
      for (int r = 0; r < 4; r++) begin
        write_map(reg_idx_t'(r), $urandom());
      end
      repeat (PHASE_ITEMS) begin
        rpt = next_report(rpt);
        send_report(rpt, '0);
      end
    end

    idle_on <= 1'b1;
    foreach (halt_rows[r]) begin
      run_row(halt_rows[r]);
    end
    settle();

    if (mismatches == 0 && expected_keys.size() == 0) begin
      $display("gamepad_report_to_key_events verification clean");
    end else begin
      $display("gamepad_report_to_key_events verification failed");
    end
    $finish;
  end

endmodule
